// ===== hw/rtl/vsnd_pkg.sv =====
`default_nettype none
package vsnd_pkg;

  localparam int unsigned Capacity = 1024;
  localparam int unsigned AddrW    = $clog2(Capacity);
  localparam int unsigned CountW   = $clog2(Capacity + 1);

  localparam logic [63:0] SAT64 = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_QUERY   = 2'd1,
    OP_NEAREST = 2'd2,
    OP_UNUSED  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DLD,
    S_DIV,
    S_FRD,
    S_FCMP,
    S_LIM,
    S_LIM2,
    S_NRD,
    S_NMUL1,
    S_NDIFF,
    S_NMUL2,
    S_NACC,
    S_SQI,
    S_SQ,
    S_FIN
  } state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/voxel_set_nearest_distance.sv =====
// The point is first quantised with a shared 32-step divider, one axis after another; then
// insert and occupancy scan the stored keys for a match, and a nearest query visits all N
// stored voxels (N at most 1024) through the key memory read port and the single shared
// multiplier, then takes a square root. One transaction is processed at a time.
// Reset (synchronous, active low) empties the set and sets resolution to 1.0; the key memory
// itself is not cleared, as only entries below the fill count are ever read.
`default_nettype none
module voxel_set_nearest_distance (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // operation[1:0], point_x[33:2], point_y[65:34], point_z[97:66], radius[128:98]
  input  wire logic [135:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // is_occupied[0], inserted_new[1], table_full[2], distance[33:3], distance_found[34]
  output logic [39:0]       out_tdata,
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [2:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  localparam int unsigned AW = vsnd_pkg::AddrW;
  localparam int unsigned CW = vsnd_pkg::CountW;

  vsnd_pkg::state_t state_r, state_nxt;

  logic [30:0] res_cfg_r;
  logic [1:0]  op_r, op_nxt;
  logic signed [31:0] p_r [3];
  logic [31:0] key_r [3];
  logic [30:0] maxd_r, maxd_nxt;
  logic [30:0] r_r, r_nxt;
  logic [1:0]  axis_r, axis_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [31:0] num_r, num_nxt;
  logic [30:0] rem_r, rem_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [95:0] mem [vsnd_pkg::Capacity];
  logic [95:0] rd_data_r;
  logic [AW-1:0] rd_addr;
  logic        wr_en;
  logic signed [67:0] mul_r, mul_nxt, mul_p;
  logic signed [33:0] mul_a, mul_b;
  logic [31:0] abs_r, abs_nxt;
  logic        sat_r, sat_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] best_r, best_nxt;
  logic [63:0] limit_r, limit_nxt;
  logic        found_r, found_nxt;
  logic [63:0] x_r, x_nxt;
  logic [63:0] sq_res_r, sq_res_nxt;
  logic [63:0] bit_r, bit_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [39:0] out_data_r, out_data_nxt;
  logic        fin_go;
  logic        do_insert;

  logic        cfg_wr;
  logic [31:0] key_cur;
  logic signed [31:0] p_cur;
  logic [31:0] trial;
  logic signed [43:0] dlt;
  logic [43:0] dabs;
  logic [63:0] sq;
  logic [64:0] sum65;
  logic [63:0] acc_new;
  logic [63:0] sq_try;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2] == 1'b0);
  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ? {1'b0, res_cfg_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_cfg_r <= 31'd65536;
    end else if (cfg_wr) begin
      res_cfg_r <= cfg_pwdata[30:0];
    end
  end

  assign in_tready  = (state_r == vsnd_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Key memory: one write port at the fill count, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[AW-1:0]] <= {key_r[2], key_r[1], key_r[0]};
    end
    rd_data_r <= mem[rd_addr];
  end

  assign key_cur = rd_data_r[32*axis_r +: 32];
  assign p_cur   = p_r[axis_r];
  assign mul_p   = mul_a * mul_b;
  assign trial   = {rem_r, num_r[31]};
  assign fin_go  = !out_valid_r || out_tready;

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    maxd_nxt   = maxd_r;
    r_nxt      = r_r;
    axis_nxt   = axis_r;
    cnt_nxt    = cnt_r;
    num_nxt    = num_r;
    rem_nxt    = rem_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    mul_nxt    = mul_r;
    abs_nxt    = abs_r;
    sat_nxt    = sat_r;
    acc_nxt    = acc_r;
    best_nxt   = best_r;
    limit_nxt  = limit_r;
    found_nxt  = found_r;
    x_nxt      = x_r;
    sq_res_nxt = sq_res_r;
    bit_nxt    = bit_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    rd_addr    = idx_r[AW-1:0];
    wr_en      = 1'b0;
    do_insert  = 1'b0;
    mul_a      = {2'b00, maxd_r, 1'b0};
    mul_b      = {2'b00, maxd_r, 1'b0};
    dlt        = '0;
    dabs       = '0;
    sq         = '0;
    sum65      = '0;
    acc_new    = '0;
    sq_try     = '0;

    unique case (state_r)
      vsnd_pkg::S_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = in_tdata[1:0];
          maxd_nxt  = in_tdata[128:98];
          r_nxt     = (res_cfg_r == 31'd0) ? 31'd1 : res_cfg_r;
          axis_nxt  = 2'd0;
          state_nxt = vsnd_pkg::S_DLD;
        end
      end
      vsnd_pkg::S_DLD: begin
        num_nxt   = p_cur[31] ? 32'(-p_cur) : p_cur;
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = vsnd_pkg::S_DIV;
      end
      vsnd_pkg::S_DIV: begin
        // Restoring division of the magnitude, one quotient bit per cycle.
        if (trial >= {1'b0, r_r}) begin
          rem_nxt = 31'(trial - {1'b0, r_r});
          num_nxt = {num_r[30:0], 1'b1};
        end else begin
          rem_nxt = trial[30:0];
          num_nxt = {num_r[30:0], 1'b0};
        end
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          if (axis_r == 2'd2) begin
            axis_nxt = 2'd0;
            idx_nxt  = '0;
            found_nxt = 1'b0;
            priority case (op_r)
              vsnd_pkg::OP_INSERT, vsnd_pkg::OP_QUERY: state_nxt = vsnd_pkg::S_FRD;
              vsnd_pkg::OP_NEAREST: state_nxt = vsnd_pkg::S_LIM;
              default: state_nxt = vsnd_pkg::S_FIN;
            endcase
          end else begin
            axis_nxt  = axis_r + 2'd1;
            state_nxt = vsnd_pkg::S_DLD;
          end
        end
      end
      vsnd_pkg::S_FRD: begin
        if (idx_r == count_r) begin
          state_nxt = vsnd_pkg::S_FIN;
        end else begin
          state_nxt = vsnd_pkg::S_FCMP;
        end
      end
      vsnd_pkg::S_FCMP: begin
        if (rd_data_r == {key_r[2], key_r[1], key_r[0]}) begin
          found_nxt = 1'b1;
          state_nxt = vsnd_pkg::S_FIN;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          rd_addr   = AW'(idx_r + 1'b1);
          state_nxt = vsnd_pkg::S_FRD;
        end
      end
      vsnd_pkg::S_LIM: begin
        mul_nxt   = mul_p;
        state_nxt = vsnd_pkg::S_LIM2;
      end
      vsnd_pkg::S_LIM2: begin
        limit_nxt = mul_r[63:0];
        best_nxt  = mul_r[63:0];
        state_nxt = vsnd_pkg::S_NRD;
      end
      vsnd_pkg::S_NRD: begin
        axis_nxt = 2'd0;
        acc_nxt  = '0;
        if (idx_r == count_r) begin
          state_nxt = vsnd_pkg::S_SQI;
        end else begin
          state_nxt = vsnd_pkg::S_NMUL1;
        end
      end
      vsnd_pkg::S_NMUL1: begin
        // Voxel centre in units of 2^-17: (2*key + 1) * resolution.
        mul_a     = {key_cur[31], key_cur, 1'b1};
        mul_b     = {3'b000, r_r};
        mul_nxt   = mul_p;
        state_nxt = vsnd_pkg::S_NDIFF;
      end
      vsnd_pkg::S_NDIFF: begin
        dlt  = $signed({{2{mul_r[41]}}, mul_r[41:0]}) - $signed({{11{p_cur[31]}}, p_cur, 1'b0});
        dabs = dlt[43] ? 44'(-dlt) : dlt;
        sat_nxt = (mul_r >= 68'sh100_0000_0000) || (mul_r <= -68'sh100_0000_0000) ||
                  (dabs[43:32] != 12'd0);
        abs_nxt   = dabs[31:0];
        state_nxt = vsnd_pkg::S_NMUL2;
      end
      vsnd_pkg::S_NMUL2: begin
        mul_a     = {2'b00, abs_r};
        mul_b     = {2'b00, abs_r};
        mul_nxt   = mul_p;
        state_nxt = vsnd_pkg::S_NACC;
      end
      vsnd_pkg::S_NACC: begin
        sq      = sat_r ? vsnd_pkg::SAT64 : mul_r[63:0];
        sum65   = {1'b0, acc_r} + {1'b0, sq};
        acc_new = sum65[64] ? vsnd_pkg::SAT64 : sum65[63:0];
        acc_nxt = acc_new;
        if (axis_r == 2'd2) begin
          if (acc_new < best_r) begin
            best_nxt = acc_new;
          end
          idx_nxt   = idx_r + 1'b1;
          rd_addr   = AW'(idx_r + 1'b1);
          state_nxt = vsnd_pkg::S_NRD;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = vsnd_pkg::S_NMUL1;
        end
      end
      vsnd_pkg::S_SQI: begin
        found_nxt  = (count_r != '0) && (best_r < limit_r);
        x_nxt      = best_r;
        sq_res_nxt = '0;
        bit_nxt    = 64'h4000_0000_0000_0000;
        cnt_nxt    = '0;
        state_nxt  = vsnd_pkg::S_SQ;
      end
      vsnd_pkg::S_SQ: begin
        // Digit-by-digit integer square root, one result bit per cycle.
        sq_try = sq_res_r + bit_r;
        if (x_r >= sq_try) begin
          x_nxt      = x_r - sq_try;
          sq_res_nxt = (sq_res_r >> 1) + bit_r;
        end else begin
          sq_res_nxt = sq_res_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          state_nxt = vsnd_pkg::S_FIN;
        end
      end
      vsnd_pkg::S_FIN: begin
        if (fin_go) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          unique case (op_r)
            vsnd_pkg::OP_INSERT: begin
              if (!found_r) begin
                if (count_r < CW'(vsnd_pkg::Capacity)) begin
                  do_insert       = 1'b1;
                  wr_en           = 1'b1;
                  count_nxt       = count_r + 1'b1;
                  out_data_nxt[1] = 1'b1;
                end else begin
                  out_data_nxt[2] = 1'b1;
                end
              end
            end
            vsnd_pkg::OP_QUERY: out_data_nxt[0] = found_r;
            vsnd_pkg::OP_NEAREST: begin
              if (found_r) begin
                out_data_nxt[33:3] = sq_res_r[31:1];
                out_data_nxt[34]   = 1'b1;
              end
            end
            default: out_data_nxt = '0;
          endcase
          state_nxt = vsnd_pkg::S_IDLE;
        end
      end
      default: state_nxt = vsnd_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vsnd_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == vsnd_pkg::S_IDLE && in_tvalid) begin
      p_r[0] <= in_tdata[33:2];
      p_r[1] <= in_tdata[65:34];
      p_r[2] <= in_tdata[97:66];
    end
    if (state_r == vsnd_pkg::S_DIV && cnt_r == 5'd31) begin
      if (p_cur[31]) begin
        key_r[axis_r] <= (rem_nxt != 31'd0) ? ~num_nxt : 32'(-num_nxt);
      end else begin
        key_r[axis_r] <= num_nxt;
      end
    end
    op_r       <= op_nxt;
    maxd_r     <= maxd_nxt;
    r_r        <= r_nxt;
    axis_r     <= axis_nxt;
    cnt_r      <= cnt_nxt;
    num_r      <= num_nxt;
    rem_r      <= rem_nxt;
    idx_r      <= idx_nxt;
    mul_r      <= mul_nxt;
    abs_r      <= abs_nxt;
    sat_r      <= sat_nxt;
    acc_r      <= acc_nxt;
    best_r     <= best_nxt;
    limit_r    <= limit_nxt;
    found_r    <= found_nxt;
    x_r        <= x_nxt;
    sq_res_r   <= sq_res_nxt;
    bit_r      <= bit_nxt;
    out_data_r <= out_data_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(vsnd_pkg::Capacity))
    else $error("fill count exceeds capacity");

  a_insert_counts: assert property (@(posedge clk) disable iff (!rst_n)
    do_insert |=> count_r == $past(count_r) + 1'b1)
    else $error("new key stored without advancing the fill count");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $countones(out_data_r[2:0]) <= 1 &&
                    !(out_data_r[34] && out_data_r[2:0] != 3'd0))
    else $error("result carries flags of more than one operation");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("new transaction taken while one is in progress");

endmodule
`default_nettype wire
